// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked and combinational property checks used by the tracker rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while rst is high
`define ASSERT_CLKD(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression that must hold at every edge, reset included
`define ASSERT_COMB(name, expr, msg) \
  name: assert property (@(posedge clk) expr) else $error(msg);

`endif

// ===== rtl/eprt_pkg.sv =====
// ----------------------------------------------------------------------------
// eprt_pkg
// shared constants and types of the echo pulse range tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eprt_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int CHAN_W    = 4;
  localparam int CFG_IDX_W = 8;

  localparam int S_TDATA_W = 72;  // channel, time_us, cal_value, padded
  localparam int M_TDATA_W = 40;  // range_value, was_fresh, connected, padded

  // operation codes carried in s_tuser
  localparam logic [FUNC_W-1:0] FUNC_RISE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FALL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CONN = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_GAIN = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_OFFS = 3'd5;

  // reply kinds carried in m_tuser
  localparam logic REPLY_RANGE = 1'b0;
  localparam logic REPLY_CONN  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCONNECT = 8'd1;

  localparam logic [DATA_W-1:0] MAX_PULSE_RESET  = 32'd70000000;
  localparam logic [DATA_W-1:0] DISCONNECT_RESET = 32'd5000000;
  localparam logic [DATA_W-1:0] GAIN_RESET       = 32'd1;

  // measurement memory entry
  typedef struct packed {
    logic              fresh;
    logic [DATA_W-1:0] filt_range;
    logic [DATA_W-1:0] edge_time;
  } meas_entry_t;

  // calibration memory entry
  typedef struct packed {
    logic [DATA_W-1:0] gain;
    logic [DATA_W-1:0] offset;
  } cal_entry_t;

endpackage

`default_nettype wire

// ===== rtl/eprt_ram.sv =====
// ----------------------------------------------------------------------------
// eprt_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eprt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/echo_pulse_range_tracker.sv =====
// ----------------------------------------------------------------------------
// echo_pulse_range_tracker
// multi-channel echo pulse width tracker with filtered, calibrated range
// ----------------------------------------------------------------------------
// Each input beat names an operation (s_tuser), a channel, a microsecond
// timestamp and a calibration value. Rising edges store the timestamp, falling
// edges turn the pulse width into a low-pass filtered range per channel, reads
// return range*gain+offset with the fresh flag, connection queries report
// whether an edge was seen within disconnect_us, and set operations load the
// per-channel gain and offset. Reads and connection queries give one output
// beat, everything else none. An item has an accept cycle, which starts the
// read of the channel's entry in the two state memories, and an update cycle,
// which computes the result and writes the entry back. Each item is a single
// memory read-modify-write, so none is taken before it ends. The update cycle
// extends while a reply must wait for a still-occupied output register. State
// entries carry valid bits cleared by reset, so no clearing pass is needed
// and the block accepts items from the first cycle after reset. The config
// port is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module echo_pulse_range_tracker
  import eprt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // channel[3:0], time_us[35:4], cal_value[67:36]
  input  wire logic [FUNC_W-1:0]    s_tuser,   // func[2:0]
  // reply stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata,   // range_value[31:0], was_fresh[32], connected[33]
  output logic                      m_tuser,   // reply_kind[0]
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // configuration registers
  logic [DATA_W-1:0] max_pulse_us;
  logic [DATA_W-1:0] disconnect_us;

  // item held during the update cycle
  logic [FUNC_W-1:0] cur_func;
  logic [CH_AW-1:0]  cur_addr;
  logic              cur_in_range;
  logic [DATA_W-1:0] cur_time;
  logic [DATA_W-1:0] cur_cal;

  // per-entry valid bits, an invalid entry reads as its reset value
  logic [CHANNELS-1:0] meas_valid;
  logic [CHANNELS-1:0] cal_valid;

  // unpacked input beat
  logic [CHAN_W-1:0] in_channel;
  logic [DATA_W-1:0] in_time;
  logic [DATA_W-1:0] in_cal;
  logic [CH_AW-1:0]  in_addr;
  logic              in_accept;

  // memory ports
  meas_entry_t meas_rdata, meas_wdata, meas_cur;
  cal_entry_t  cal_rdata, cal_wdata, cal_cur;
  logic        meas_we, cal_we;

  // update-cycle datapath
  logic [DATA_W-1:0] pulse_width;
  logic              fall_ok;
  logic [DATA_W-1:0] filt_sum;
  logic [DATA_W-1:0] filt_next;
  logic [DATA_W-1:0] cal_prod;
  logic [DATA_W-1:0] cal_range;
  logic              conn_now;
  logic              has_reply;
  logic              stall;
  logic              commit;
  logic              out_load;

  assign in_channel = s_tdata[3:0];
  assign in_time    = s_tdata[35:4];
  assign in_cal     = s_tdata[67:36];
  assign in_addr    = CH_AW'(in_channel);

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // state memories: edge time, filtered range and fresh flag in one,
  // gain and offset in the other
  // ---------------------------------------------------------------------------
  eprt_ram #(
    .WIDTH ($bits(meas_entry_t)),
    .DEPTH (CHANNELS)
  ) u_meas_ram (
    .clk   (clk),
    .we    (meas_we),
    .waddr (cur_addr),
    .wdata (meas_wdata),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (meas_rdata)
  );

  eprt_ram #(
    .WIDTH ($bits(cal_entry_t)),
    .DEPTH (CHANNELS)
  ) u_cal_ram (
    .clk   (clk),
    .we    (cal_we),
    .waddr (cur_addr),
    .wdata (cal_wdata),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (cal_rdata)
  );

  // never-written entries fall back to reset values
  always_comb begin
    if (meas_valid[cur_addr]) begin
      meas_cur = meas_rdata;
    end else begin
      meas_cur = '0;
    end
    if (cal_valid[cur_addr]) begin
      cal_cur = cal_rdata;
    end else begin
      cal_cur.gain   = GAIN_RESET;
      cal_cur.offset = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // update-cycle arithmetic
  // ---------------------------------------------------------------------------
  // width modulo 2^32; zero edge time means no rising edge seen
  assign pulse_width = cur_time - meas_cur.edge_time;
  assign fall_ok     = (meas_cur.edge_time != '0) && (pulse_width < max_pulse_us);

  // (width*7 + old) / 8, all wrapping at 32 bits
  assign filt_sum  = (pulse_width << 3) - pulse_width + meas_cur.filt_range;
  assign filt_next = filt_sum >> 3;

  // low 32 bits of range*gain, then offset
  assign cal_prod  = meas_cur.filt_range * cal_cur.gain;
  assign cal_range = cal_prod + cal_cur.offset;

  assign conn_now = !(pulse_width >= disconnect_us);

  assign has_reply = cur_in_range && ((cur_func == FUNC_READ) || (cur_func == FUNC_CONN));
  // hold the update while the previous reply still sits in the output register
  assign stall     = has_reply && m_tvalid && !m_tready;
  assign commit    = (state == ST_EXEC) && !stall;
  assign out_load  = commit && has_reply;

  // write-back of the entry
  always_comb begin
    meas_wdata = meas_cur;
    cal_wdata  = cal_cur;
    meas_we    = 1'b0;
    cal_we     = 1'b0;
    case (cur_func)
      FUNC_RISE: begin
        meas_wdata.edge_time = cur_time;
        meas_we              = 1'b1;
      end
      FUNC_FALL: begin
        meas_wdata.filt_range = filt_next;
        meas_wdata.fresh      = 1'b1;
        meas_we               = fall_ok;
      end
      FUNC_READ: begin
        meas_wdata.fresh = 1'b0;
        meas_we          = 1'b1;
      end
      FUNC_GAIN: begin
        cal_wdata.gain = cur_cal;
        cal_we         = 1'b1;
      end
      FUNC_OFFS: begin
        cal_wdata.offset = cur_cal;
        cal_we           = 1'b1;
      end
      default: begin
      end
    endcase
    meas_we = meas_we && commit && cur_in_range;
    cal_we  = cal_we && commit && cur_in_range;
  end

  // ---------------------------------------------------------------------------
  // item capture, valid bits and configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_func     <= s_tuser;
      cur_addr     <= in_addr;
      cur_in_range <= (32'(in_channel) < 32'(CHANNELS));
      cur_time     <= in_time;
      cur_cal      <= in_cal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meas_valid <= '0;
      cal_valid  <= '0;
    end else begin
      if (meas_we) begin
        meas_valid[cur_addr] <= 1'b1;
      end
      if (cal_we) begin
        cal_valid[cur_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pulse_us  <= MAX_PULSE_RESET;
      disconnect_us <= DISCONNECT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_PULSE:  max_pulse_us  <= cfg_data;
        REG_DISCONNECT: disconnect_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer and reply register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // a new reply replaces one that leaves in the same cycle
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    if (out_load) begin
      if (cur_func == FUNC_READ) begin
        m_tuser <= REPLY_RANGE;
        m_tdata <= {6'd0, 1'b0, meas_cur.fresh, cal_range};
      end else begin
        m_tuser <= REPLY_CONN;
        m_tdata <= {6'd0, conn_now, 1'b0, 32'd0};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `ASSERT_COMB(a_no_accept_in_exec, rst || !(s_tready && state == ST_EXEC), "input taken during update")
  `ASSERT_CLKD(a_accept_to_exec, in_accept |=> state == ST_EXEC, "accept did not start update")
  `ASSERT_CLKD(a_write_in_exec, (meas_we || cal_we) |-> state == ST_EXEC && cur_in_range,
    "memory written outside update")
  `ASSERT_CLKD(a_reply_kind, out_load |-> (cur_func == FUNC_READ || cur_func == FUNC_CONN),
    "reply from an operation without one")
  `ASSERT_CLKD(a_read_clears_fresh, (meas_we && cur_func == FUNC_READ) |-> !meas_wdata.fresh,
    "read left fresh flag set")
  `ASSERT_CLKD(a_stall_holds, (state == ST_EXEC && stall) |=> state == ST_EXEC && $stable(cur_addr),
    "update dropped while reply blocked")

endmodule

`default_nettype wire

// ===== test/tb_echo_pulse_range_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_echo_pulse_range_tracker
// ----------------------------------------------------------------------------
// Self-checking bench for the echo pulse range tracker. Input beats drive the
// block and also step a local copy of the per-channel state. That copy holds
// the edge times, the filtered ranges, the fresh flags, the gain, the offset
// and both limit registers. Every read or connection query that is accepted
// queues the reply it must produce. Each reply beat is then checked field by
// field against the oldest queued reply. The run starts with directed
// corners: reset state, no stored edge, timestamp wrap, widths at the limit,
// calibration extremes, unused operations, and limit registers at both ends,
// including writes to unmapped indexes. Then come random phases with varied
// register settings, random input gaps and random reply backpressure.
// ----------------------------------------------------------------------------
module tb_echo_pulse_range_tracker
  import eprt_pkg::*;
();

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;       // wait after the last reply so the last item can finish
  localparam int DRAIN_LIMIT   = 20000;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 210;

  // operation codes the block must ignore
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  // register indexes with nothing behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

  localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct {
    logic              reply_kind;
    logic [DATA_W-1:0] range_value;
    logic              was_fresh;
    logic              connected;
  } reply_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;    // channel[3:0], time_us[35:4], cal_value[67:36]
  logic [FUNC_W-1:0]    s_tuser;    // func[2:0]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;    // range_value[31:0], was_fresh[32], connected[33]
  logic                 m_tuser;    // reply_kind[0]
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  // local copy of the tracker state
  logic [DATA_W-1:0] echo_edge  [CHANNELS];
  logic [DATA_W-1:0] range_acc  [CHANNELS];
  logic              fresh_mark [CHANNELS];
  logic [DATA_W-1:0] gain_cal   [CHANNELS];
  logic [DATA_W-1:0] offset_cal [CHANNELS];
  logic [DATA_W-1:0] max_pulse_lim;
  logic [DATA_W-1:0] disconnect_lim;

  reply_t pending_replies[$];
  reply_t due_reply;

  logic              steady_flow;   // no idling on either side while set
  logic [DATA_W-1:0] clock_us;      // free-running time base for random items
  int                fail_count;
  int                ready_hold;
  int                ready_roll;
  int                cycle_count = 0;

  echo_pulse_range_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // step the local state for one accepted input beat, queue its reply
  task automatic track_echo_item(input logic [FUNC_W-1:0] func,
                                 input logic [CHAN_W-1:0] ch,
                                 input logic [DATA_W-1:0] now,
                                 input logic [DATA_W-1:0] cal);
    logic [DATA_W-1:0] span;
    reply_t            r;
    span          = now - echo_edge[ch];
    r.reply_kind  = REPLY_RANGE;
    r.range_value = '0;
    r.was_fresh   = 1'b0;
    r.connected   = 1'b0;
    case (func)
      FUNC_RISE: echo_edge[ch] = now;
      FUNC_FALL: begin
        // zero edge time means no rising edge seen yet
        if (echo_edge[ch] != '0 && span < max_pulse_lim) begin
          range_acc[ch]  = (span * 32'd7 + range_acc[ch]) / 32'd8;
          fresh_mark[ch] = 1'b1;
        end
      end
      FUNC_READ: begin
        r.range_value  = range_acc[ch] * gain_cal[ch] + offset_cal[ch];
        r.was_fresh    = fresh_mark[ch];
        fresh_mark[ch] = 1'b0;
        pending_replies.push_back(r);
      end
      FUNC_CONN: begin
        r.reply_kind = REPLY_CONN;
        r.connected  = (span < disconnect_lim);
        pending_replies.push_back(r);
      end
      FUNC_GAIN: gain_cal[ch] = cal;
      FUNC_OFFS: offset_cal[ch] = cal;
      default: ;  // spare codes do nothing
    endcase
  endtask

  // observe all three interfaces at the rising edge: register writes and input
  // beats update the local state first, then a reply beat is checked
  always @(posedge clk) begin
    if (rst) begin
      max_pulse_lim  = MAX_PULSE_RESET;
      disconnect_lim = DISCONNECT_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        echo_edge[i]  = '0;
        range_acc[i]  = '0;
        fresh_mark[i] = 1'b0;
        gain_cal[i]   = GAIN_RESET;
        offset_cal[i] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_PULSE) max_pulse_lim = cfg_data;
        else if (cfg_index == REG_DISCONNECT) disconnect_lim = cfg_data;
      end
      if (s_tvalid && s_tready)
        track_echo_item(s_tuser, s_tdata[3:0], s_tdata[35:4], s_tdata[67:36]);
      if (m_tvalid && m_tready) begin
        if (pending_replies.size() == 0) begin
          $error("reply beat with nothing expected: kind %0d data %h", m_tuser, m_tdata);
          fail_count++;
        end else begin
          due_reply = pending_replies.pop_front();
          if (m_tuser !== due_reply.reply_kind) begin
            $error("reply_kind mismatch: expected %0d, actual %0d",
                   due_reply.reply_kind, m_tuser);
            fail_count++;
          end
          if (m_tdata[31:0] !== due_reply.range_value) begin
            $error("range_value mismatch: expected %h, actual %h",
                   due_reply.range_value, m_tdata[31:0]);
            fail_count++;
          end
          if (m_tdata[32] !== due_reply.was_fresh) begin
            $error("was_fresh mismatch: expected %0d, actual %0d",
                   due_reply.was_fresh, m_tdata[32]);
            fail_count++;
          end
          if (m_tdata[33] !== due_reply.connected) begin
            $error("connected mismatch: expected %0d, actual %0d",
                   due_reply.connected, m_tdata[33]);
            fail_count++;
          end
        end
      end
    end
  end

  // reply side backpressure: mostly ready, short stalls, now and then a long one
  always @(negedge clk) begin
    if (steady_flow) begin
      m_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      m_tready <= 1'b0;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 65) begin
        m_tready <= 1'b1;
      end else begin
        m_tready   <= 1'b0;
        ready_hold = (ready_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // idle cycles after an input beat
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input beat; entered and left at a falling edge, valid stays up on no gap
  task automatic send_echo_item(input logic [FUNC_W-1:0] func,
                                input logic [CHAN_W-1:0] ch,
                                input logic [DATA_W-1:0] stamp,
                                input logic [DATA_W-1:0] cal);
    int gap;
    s_tuser  <= func;
    s_tdata  <= {4'b0000, cal, stamp, ch};
    s_tvalid <= 1'b1;
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // one register write; the block must be idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and wait for every queued reply, then let the last item finish
  task automatic wait_replies_drained();
    int guard;
    guard    = 0;
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d expected replies never arrived", pending_replies.size());
      fail_count++;
      pending_replies.delete();
    end
  endtask

  // state right after reset: zero range, no fresh flag, connected until silence
  task automatic test_reset_state();
    send_echo_item(FUNC_READ, 4'd0, '0, '0);
    send_echo_item(FUNC_READ, 4'd15, ALL_ONES, ALL_ONES);
    send_echo_item(FUNC_CONN, 4'd0, DISCONNECT_RESET - 32'd1, '0);
    send_echo_item(FUNC_CONN, 4'd15, DISCONNECT_RESET, '0);
    wait_replies_drained();
  endtask

  task automatic test_edge_cases();
    // a rising edge at time zero looks like no edge, so the fall is dropped
    send_echo_item(FUNC_RISE, 4'd1, '0, '0);
    send_echo_item(FUNC_FALL, 4'd1, 32'd500, '0);
    send_echo_item(FUNC_READ, 4'd1, 32'd600, '0);
    // pulse that spans the timestamp wrap
    send_echo_item(FUNC_RISE, 4'd2, 32'hFFFF_FF00, '0);
    send_echo_item(FUNC_FALL, 4'd2, 32'h0000_0100, '0);
    // width one below the limit is kept, width at the limit is dropped
    send_echo_item(FUNC_RISE, 4'd3, 32'd1000, '0);
    send_echo_item(FUNC_FALL, 4'd3, 32'd1000 + MAX_PULSE_RESET - 32'd1, '0);
    send_echo_item(FUNC_RISE, 4'd3, 32'd5, '0);
    send_echo_item(FUNC_FALL, 4'd3, 32'd5 + MAX_PULSE_RESET, '0);
    // calibration extremes; second read sees the fresh flag cleared
    send_echo_item(FUNC_GAIN, 4'd2, '0, 32'h7FFF_FFFF);
    send_echo_item(FUNC_OFFS, 4'd2, '0, 32'h8000_0000);
    send_echo_item(FUNC_READ, 4'd2, '0, '0);
    send_echo_item(FUNC_READ, 4'd2, '0, '0);
    send_echo_item(FUNC_GAIN, 4'd3, '0, ALL_ONES);
    send_echo_item(FUNC_OFFS, 4'd3, '0, 32'h7FFF_FFFF);
    send_echo_item(FUNC_READ, 4'd3, '0, '0);
    // unused codes with every data bit set
    send_echo_item(FUNC_SPARE_LO, 4'd4, ALL_ONES, ALL_ONES);
    send_echo_item(FUNC_SPARE_HI, 4'd15, ALL_ONES, ALL_ONES);
    // silence one below and exactly at the disconnect limit
    send_echo_item(FUNC_CONN, 4'd3, 32'd5 + DISCONNECT_RESET - 32'd1, '0);
    send_echo_item(FUNC_CONN, 4'd3, 32'd5 + DISCONNECT_RESET, '0);
    wait_replies_drained();
  endtask

  task automatic test_register_extremes();
    // writes to unmapped indexes must leave both limits alone
    write_register(REG_UNMAPPED, 32'd1);
    write_register(REG_TOP_INDEX, 32'd1);
    send_echo_item(FUNC_RISE, 4'd7, 32'd200, '0);
    send_echo_item(FUNC_FALL, 4'd7, 32'd200 + MAX_PULSE_RESET - 32'd1, '0);
    send_echo_item(FUNC_READ, 4'd7, '0, '0);
    send_echo_item(FUNC_CONN, 4'd7, 32'd200 + DISCONNECT_RESET - 32'd1, '0);
    wait_replies_drained();

    // smallest limits: only a zero width counts, one microsecond is silence
    write_register(REG_MAX_PULSE, 32'd1);
    write_register(REG_DISCONNECT, 32'd1);
    send_echo_item(FUNC_RISE, 4'd5, 32'd77, '0);
    send_echo_item(FUNC_FALL, 4'd5, 32'd77, '0);
    send_echo_item(FUNC_FALL, 4'd5, 32'd78, '0);
    send_echo_item(FUNC_CONN, 4'd5, 32'd77, '0);
    send_echo_item(FUNC_CONN, 4'd5, 32'd78, '0);
    send_echo_item(FUNC_READ, 4'd5, '0, '0);
    wait_replies_drained();

    // largest limits: only the all-ones span is rejected
    write_register(REG_MAX_PULSE, ALL_ONES);
    write_register(REG_DISCONNECT, ALL_ONES);
    send_echo_item(FUNC_RISE, 4'd6, 32'd10, '0);
    send_echo_item(FUNC_FALL, 4'd6, 32'd9, '0);
    send_echo_item(FUNC_FALL, 4'd6, 32'd8, '0);
    send_echo_item(FUNC_CONN, 4'd6, 32'd9, '0);
    send_echo_item(FUNC_CONN, 4'd6, 32'd8, '0);
    send_echo_item(FUNC_READ, 4'd6, '0, '0);
    wait_replies_drained();
  endtask

  // mostly rise/fall pairs with random widths around the limit, plus reads,
  // queries, calibration, stray edges and ignored codes
  task automatic run_random_traffic(input int n_items);
    int                sent;
    int                sel;
    bit                paused;
    logic [CHAN_W-1:0] ch;
    logic [DATA_W-1:0] width;
    logic [DATA_W-1:0] stamp;
    logic [DATA_W-1:0] cal;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      ch       = $urandom_range(0, CHANNELS - 1);
      sel      = $urandom_range(0, 99);
      clock_us = clock_us + $urandom_range(1, 3000);
      if (sel < 35) begin
        case ($urandom_range(0, 4))
          0: width = max_pulse_lim - 32'd1;
          1: width = max_pulse_lim;
          2: width = $urandom_range(0, 4000);
          3: width = $urandom % max_pulse_lim;
          default: width = $urandom;
        endcase
        send_echo_item(FUNC_RISE, ch, clock_us, $urandom);
        clock_us = clock_us + width;
        send_echo_item(FUNC_FALL, ch, clock_us, $urandom);
        sent += 2;
        if ($urandom_range(0, 1)) begin
          send_echo_item(FUNC_READ, ch, clock_us, $urandom);
          sent++;
        end
      end else if (sel < 55) begin
        send_echo_item(FUNC_READ, ch, clock_us, $urandom);
        sent++;
      end else if (sel < 70) begin
        // nearly half of the queries land at or next to the disconnect limit
        if (sel < 62) stamp = echo_edge[ch] + disconnect_lim - 32'd1 + $urandom_range(0, 2);
        else stamp = clock_us;
        send_echo_item(FUNC_CONN, ch, stamp, $urandom);
        sent++;
      end else if (sel < 76) begin
        case ($urandom_range(0, 2))
          0: cal = $urandom_range(0, 16);
          1: cal = 32'd0 - $urandom_range(1, 16);
          default: cal = $urandom;
        endcase
        send_echo_item(FUNC_GAIN, ch, $urandom, cal);
        sent++;
      end else if (sel < 82) begin
        send_echo_item(FUNC_OFFS, ch, $urandom, $urandom);
        sent++;
      end else if (sel < 90) begin
        send_echo_item($urandom_range(0, 1) ? FUNC_RISE : FUNC_FALL, ch, $urandom, $urandom);
        sent++;
      end else if (sel < 95) begin
        // ignored codes, not counted
        send_echo_item($urandom_range(0, 1) ? FUNC_SPARE_LO : FUNC_SPARE_HI, ch,
                       $urandom, $urandom);
      end else begin
        // falling edge with no matching rise
        send_echo_item(FUNC_FALL, ch, clock_us, $urandom);
        sent++;
      end
      // hold the sender once mid-phase until all replies are back
      if (!paused && sent >= n_items / 2) begin
        wait_replies_drained();
        paused = 1'b1;
      end
    end
    wait_replies_drained();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_register(REG_MAX_PULSE, MAX_PULSE_RESET);
          write_register(REG_DISCONNECT, DISCONNECT_RESET);
        end
        1: begin
          write_register(REG_MAX_PULSE, $urandom_range(1, 5000));
          write_register(REG_DISCONNECT, $urandom_range(1, 5000));
        end
        2: begin
          write_register(REG_MAX_PULSE, $urandom_range(1, ALL_ONES));
          write_register(REG_DISCONNECT, $urandom_range(1, ALL_ONES));
        end
        3: begin
          write_register(REG_MAX_PULSE, ALL_ONES);
          write_register(REG_DISCONNECT, 32'd1);
        end
        default: begin
          write_register(REG_MAX_PULSE, 32'd1);
          write_register(REG_DISCONNECT, ALL_ONES);
        end
      endcase
      // one phase runs with no idling at all
      steady_flow = (phase == 1);
      run_random_traffic(PHASE_ITEMS);
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    m_tready    = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    steady_flow = 1'b0;
    clock_us    = 32'd1000;
    fail_count  = 0;
    ready_hold  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_edge_cases();
    test_register_extremes();
    test_random_traffic();

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
